// ----- src/csfw_pkg.sv -----
// Shared codes, widths and types of the counting semaphore block.
package csfw_pkg;

    localparam int OP_WIDTH            = 2;
    localparam int STATUS_WIDTH        = 3;
    localparam int AMOUNT_WIDTH        = 16;
    localparam int CFG_WIDTH           = 16;

    localparam int QUEUE_DEPTH_DEF     = 16;
    localparam int COUNT_WIDTH_DEF     = 16;
    localparam int THREAD_ID_WIDTH_DEF = 6;

    localparam logic [OP_WIDTH-1:0] OP_WAIT   = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_SIGNAL = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_CLOSE  = 2'd2;
    localparam logic [OP_WIDTH-1:0] OP_NONE   = 2'd3;

    localparam logic [STATUS_WIDTH-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_BLOCKED      = 3'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_WOKEN        = 3'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_WOKEN_CLOSED = 3'd3;
    localparam logic [STATUS_WIDTH-1:0] ST_REJECTED     = 3'd4;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL         = 3'd5;

    typedef struct packed {
        logic [OP_WIDTH-1:0] kind;
        logic                amt_zero;
    } t_cmd_ctl;

endpackage

// ----- src/csfw_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module csfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/csfw_front.sv -----
// Intake: decodes requests; all but operation three enter a two-entry command queue.
module csfw_front #(
    parameter int THREAD_ID_WIDTH = csfw_pkg::THREAD_ID_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [csfw_pkg::OP_WIDTH-1:0]       i_operation,
    input  logic [THREAD_ID_WIDTH-1:0]          i_thread_id,
    input  logic [csfw_pkg::AMOUNT_WIDTH-1:0]   i_amount,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output csfw_pkg::t_cmd_ctl                  o_cmd_ctl,
    output logic [THREAD_ID_WIDTH-1:0]          o_cmd_tid,
    output logic [csfw_pkg::AMOUNT_WIDTH-1:0]   o_cmd_amount
);

    csfw_pkg::t_cmd_ctl                  r_ctl [2];
    logic [THREAD_ID_WIDTH-1:0]          r_tid [2];
    logic [csfw_pkg::AMOUNT_WIDTH-1:0]   r_amt [2];
    logic [1:0]                          r_cnt;
    logic [1:0]                          n_cnt;
    logic                                r_wr_ptr;
    logic                                r_rd_ptr;
    logic                                push;
    logic                                pop;
    csfw_pkg::t_cmd_ctl                  ctl_in;

    assign o_in_ready = (r_cnt != 2'd2);
    // Operation three causes nothing and is dropped here.
    assign push = i_in_valid && o_in_ready && (i_operation != csfw_pkg::OP_NONE);
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        ctl_in.kind     = i_operation;
        ctl_in.amt_zero = (i_amount == '0);
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ctl[r_wr_ptr] <= ctl_in;
            r_tid[r_wr_ptr] <= i_thread_id;
            r_amt[r_wr_ptr] <= i_amount;
        end
    end

    assign o_cmd_valid  = (r_cnt != 2'd0);
    assign o_cmd_ctl    = r_ctl[r_rd_ptr];
    assign o_cmd_tid    = r_tid[r_rd_ptr];
    assign o_cmd_amount = r_amt[r_rd_ptr];

endmodule

// ----- src/csfw_back.sv -----
// Semaphore engine: unit count, closed flag, waiter queue and the result register.
module csfw_back #(
    parameter int QUEUE_DEPTH     = csfw_pkg::QUEUE_DEPTH_DEF,
    parameter int COUNT_WIDTH     = csfw_pkg::COUNT_WIDTH_DEF,
    parameter int THREAD_ID_WIDTH = csfw_pkg::THREAD_ID_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [csfw_pkg::CFG_WIDTH-1:0]      i_cfg_wr_data,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  csfw_pkg::t_cmd_ctl                  i_cmd_ctl,
    input  logic [THREAD_ID_WIDTH-1:0]          i_cmd_tid,
    input  logic [csfw_pkg::AMOUNT_WIDTH-1:0]   i_cmd_amount,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [THREAD_ID_WIDTH-1:0]          o_thread_id_res,
    output logic [csfw_pkg::STATUS_WIDTH-1:0]   o_status,
    output logic                                o_last
);

    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int UW     = $clog2(QUEUE_DEPTH + 1);
    localparam int AW     = csfw_pkg::AMOUNT_WIDTH;
    localparam int XW     = ((COUNT_WIDTH > AW) ? COUNT_WIDTH : AW) + 1;
    localparam int RW     = THREAD_ID_WIDTH + AW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SIG_RD  = 3'd1;
    localparam logic [2:0] S_SIG_CHK = 3'd2;
    localparam logic [2:0] S_CLS_RD  = 3'd3;
    localparam logic [2:0] S_CLS_CHK = 3'd4;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [PW-1:0]          LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [UW-1:0]          FULL_USED = UW'(QUEUE_DEPTH);

    logic [2:0]                        r_state, n_state;
    logic [COUNT_WIDTH-1:0]            r_count, n_count;
    logic                              r_closed, n_closed;
    logic [PW-1:0]                     r_head, n_head;
    logic [PW-1:0]                     r_tail, n_tail;
    logic [UW-1:0]                     r_used, n_used;
    logic [THREAD_ID_WIDTH-1:0]        r_cmd_tid, n_cmd_tid;
    logic                              r_out_valid, n_out_valid;
    logic [THREAD_ID_WIDTH-1:0]        r_out_tid, n_out_tid;
    logic [csfw_pkg::STATUS_WIDTH-1:0] r_out_st, n_out_st;
    logic                              r_out_last, n_out_last;

    logic                              out_free;
    logic                              emit;
    logic [THREAD_ID_WIDTH-1:0]        e_tid;
    logic [csfw_pkg::STATUS_WIDTH-1:0] e_st;
    logic                              e_last;

    logic                              ram_we;
    logic                              ram_re;
    logic [RW-1:0]                     ram_wdata;
    logic [RW-1:0]                     ram_rdata;
    logic [THREAD_ID_WIDTH-1:0]        rd_tid;
    logic [XW-1:0]                     count_x;
    logic [XW-1:0]                     amt_x;
    logic [XW-1:0]                     req_x;
    logic [XW-1:0]                     sum_x;
    logic [XW-1:0]                     wait_left_x;
    logic [XW-1:0]                     req_left_x;

    csfw_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_waiters (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_tail),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_head),
        .o_rd_data (ram_rdata)
    );

    assign ram_wdata   = {i_cmd_tid, i_cmd_amount};
    assign rd_tid      = ram_rdata[RW-1:AW];
    assign count_x     = XW'(r_count);
    assign amt_x       = XW'(i_cmd_amount);
    assign req_x       = XW'(ram_rdata[AW-1:0]);
    assign sum_x       = count_x + amt_x;
    assign wait_left_x = count_x - amt_x;
    assign req_left_x  = count_x - req_x;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_closed    = r_closed;
        n_head      = r_head;
        n_tail      = r_tail;
        n_used      = r_used;
        n_cmd_tid   = r_cmd_tid;
        o_cmd_ready = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        emit        = 1'b0;
        e_tid       = r_cmd_tid;
        e_st        = csfw_pkg::ST_OK;
        e_last      = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = out_free;
                if (i_cmd_valid && out_free) begin
                    n_cmd_tid = i_cmd_tid;
                    e_tid     = i_cmd_tid;
                    case (i_cmd_ctl.kind)
                        csfw_pkg::OP_WAIT: begin
                            emit = 1'b1;
                            if (r_closed) begin
                                e_st = csfw_pkg::ST_REJECTED;
                            end else if (i_cmd_ctl.amt_zero) begin
                                e_st = csfw_pkg::ST_OK;
                            end else if (r_used == '0 && count_x >= amt_x) begin
                                n_count = wait_left_x[COUNT_WIDTH-1:0];
                                e_st    = csfw_pkg::ST_OK;
                            end else if (r_used == FULL_USED) begin
                                e_st = csfw_pkg::ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                n_tail = (r_tail == LAST_SLOT) ? '0 : r_tail + PW'(1);
                                n_used = r_used + UW'(1);
                                e_st   = csfw_pkg::ST_BLOCKED;
                            end
                        end
                        csfw_pkg::OP_SIGNAL: begin
                            if (r_closed) begin
                                emit = 1'b1;
                                e_st = csfw_pkg::ST_REJECTED;
                            end else begin
                                n_count = (sum_x > XW'(COUNT_MAX)) ? COUNT_MAX
                                                                   : sum_x[COUNT_WIDTH-1:0];
                                n_state = S_SIG_RD;
                            end
                        end
                        csfw_pkg::OP_CLOSE: begin
                            n_closed = 1'b1;
                            n_state  = S_CLS_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SIG_RD: begin
                if (r_used == '0) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_SIG_CHK;
                end
            end
            S_SIG_CHK: begin
                if (count_x >= req_x) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_tid   = rd_tid;
                        e_st    = csfw_pkg::ST_WOKEN;
                        e_last  = 1'b0;
                        n_count = req_left_x[COUNT_WIDTH-1:0];
                        n_head  = (r_head == LAST_SLOT) ? '0 : r_head + PW'(1);
                        n_used  = r_used - UW'(1);
                        n_state = S_SIG_RD;
                    end
                end else if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLS_RD: begin
                if (r_used == '0) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_head  = '0;
                        n_tail  = '0;
                        n_state = S_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_CLS_CHK;
                end
            end
            S_CLS_CHK: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_tid   = rd_tid;
                    e_st    = csfw_pkg::ST_WOKEN_CLOSED;
                    e_last  = 1'b0;
                    n_head  = (r_head == LAST_SLOT) ? '0 : r_head + PW'(1);
                    n_used  = r_used - UW'(1);
                    n_state = S_CLS_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_count = COUNT_WIDTH'(XW'(i_cfg_wr_data));
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_tid   = r_out_tid;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_tid   = e_tid;
            n_out_st    = e_st;
            n_out_last  = e_last;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_closed    <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_closed    <= n_closed;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd_tid  <= n_cmd_tid;
        r_out_tid  <= n_out_tid;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_thread_id_res = r_out_tid;
    assign o_status        = r_out_st;
    assign o_last          = r_out_last;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL_USED)
        else $error("waiter queue occupancy beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) |-> (r_head == r_tail))
        else $error("empty waiter queue with head and tail apart");

    a_closed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed |=> r_closed)
        else $error("closed flag dropped without reset");

    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIG_CHK) |=> (r_state == S_SIG_CHK || r_state == S_SIG_RD ||
                                    r_state == S_IDLE))
        else $error("signal release left its loop");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIG_CHK || r_state == S_CLS_CHK) |-> (r_used != '0))
        else $error("waiter check with an empty queue");

endmodule

// ----- src/counting_semaphore_fifo_waiters_top.sv -----
// Top level of the counting semaphore with a FIFO wait queue.
//
// Requests enter on a valid/ready channel (operation, thread id, amount):
// wait, signal or close. Results leave on a valid/ready channel with the
// thread id, a status and a last flag. Operation three is taken and dropped;
// every other request gives one or more results, the final one with last set.
// A two-entry command queue parts intake from the engine, and a result
// register parts the engine from the receiver, so new requests are taken
// while a result waits.
// A wait, or any rejected request, has its result registered straight from
// the engine's idle state. A signal or close passes the command queue to the
// engine, which then reads each waiter's head from the waiter RAM and
// releases it (for a signal, once its amount fits the count) before giving
// the acknowledge; a signal that leaves waiters queued reads and checks the
// head once more first. The engine works on one request at a time; a stalled
// receiver holds it in place while intake fills the command queue until full.
// Reset: count zero, open, queue empty. The configuration write loads the
// unit count; the user makes it only while the block is idle (not enforced).
module counting_semaphore_fifo_waiters_top #(
    parameter int QUEUE_DEPTH     = csfw_pkg::QUEUE_DEPTH_DEF,
    parameter int COUNT_WIDTH     = csfw_pkg::COUNT_WIDTH_DEF,
    parameter int THREAD_ID_WIDTH = csfw_pkg::THREAD_ID_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [csfw_pkg::CFG_WIDTH-1:0]      i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [csfw_pkg::OP_WIDTH-1:0]       i_operation,
    input  logic [THREAD_ID_WIDTH-1:0]          i_thread_id,
    input  logic [csfw_pkg::AMOUNT_WIDTH-1:0]   i_amount,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [THREAD_ID_WIDTH-1:0]          o_thread_id_res,
    output logic [csfw_pkg::STATUS_WIDTH-1:0]   o_status,
    output logic                                o_last
);

    logic                                cmd_valid;
    logic                                cmd_ready;
    csfw_pkg::t_cmd_ctl                  cmd_ctl;
    logic [THREAD_ID_WIDTH-1:0]          cmd_tid;
    logic [csfw_pkg::AMOUNT_WIDTH-1:0]   cmd_amount;

    csfw_front #(
        .THREAD_ID_WIDTH (THREAD_ID_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_thread_id  (i_thread_id),
        .i_amount     (i_amount),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd_ctl    (cmd_ctl),
        .o_cmd_tid    (cmd_tid),
        .o_cmd_amount (cmd_amount)
    );

    csfw_back #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .COUNT_WIDTH     (COUNT_WIDTH),
        .THREAD_ID_WIDTH (THREAD_ID_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_ready     (cmd_ready),
        .i_cmd_ctl       (cmd_ctl),
        .i_cmd_tid       (cmd_tid),
        .i_cmd_amount    (cmd_amount),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_thread_id_res (o_thread_id_res),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule
